[rtl/uyvy_cc_pkg.sv]
// Shared widths, fixed-point coefficients and helpers for the UYVY/BGR colour converter.
`timescale 1ns / 1ps
`default_nettype none

package uyvy_cc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int BYTES     = 6;
  localparam int DATA_W    = 8 * BYTES;
  // coefficient magnitude stays below 2 * 2^FRAC_BITS, plus a sign bit
  localparam int COEF_W    = FRAC_BITS + 2;
  // signed 10-bit operand times signed coefficient
  localparam int PROD_W    = COEF_W + 10;
  localparam int SUM_W     = FRAC_BITS + 14;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [9:0]        opnd_t;

  typedef enum logic {
    DIR_YUV2BGR = 1'b0,
    DIR_BGR2YUV = 1'b1
  } dir_t;

  // round(milli / 1000 * 2^FRAC_BITS)
  function automatic coef_t coef(input longint milli);
    longint v;
    v = (milli * (longint'(1) << FRAC_BITS) + 500) / 1000;
    return COEF_W'(v);
  endfunction

  localparam coef_t C1402 = coef(1402);
  localparam coef_t C344  = coef(344);
  localparam coef_t C714  = coef(714);
  localparam coef_t C1772 = coef(1772);
  localparam coef_t C257  = coef(257);
  localparam coef_t C504  = coef(504);
  localparam coef_t C098  = coef(98);
  localparam coef_t C148  = coef(148);
  localparam coef_t C291  = coef(291);
  localparam coef_t C439  = coef(439);
  localparam coef_t C368  = coef(368);
  localparam coef_t C071  = coef(71);

  localparam sum_t OFS16  = SUM_W'(longint'(16) << FRAC_BITS);
  localparam sum_t OFS128 = SUM_W'(longint'(128) << FRAC_BITS);

  // floor to an integer, then clamp to 0..255
  function automatic logic [7:0] sat_floor(input sum_t s);
    sum_t q;
    q = s >>> FRAC_BITS;
    if (s < 0) begin
      return 8'h00;
    end
    if (q > SUM_W'(255)) begin
      return 8'hFF;
    end
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/uyvy_cc_pipe.sv]
// Four-stage arithmetic pipeline: capture, multiply, sum, clamp.
`timescale 1ns / 1ps
`default_nettype none

module uyvy_cc_pipe
  import uyvy_cc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DATA_W-1:0] in_data,
  input  wire dir_t              dir,
  output logic                   out_valid,
  output logic      [DATA_W-1:0] out_data
);

  // stage 1: captured bytes
  logic       v1, v2, v3;
  dir_t       dir1, dir2;
  logic [7:0] b1 [BYTES];

  // stage 2: products and scaled luma
  prod_t p_bu, p_gu, p_gv, p_rv;
  prod_t p_y257, p_y504, p_y098, p_u148, p_u291, p_u439;
  prod_t p_v439, p_v368, p_v071, p_z257, p_z504, p_z098;
  sum_t  yf1, yf2;

  // stage 3: sums
  sum_t  s3 [BYTES];
  sum_t  s3_next [BYTES];

  opnd_t du, dv;
  opnd_t ob [BYTES];

  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      ob[i] = opnd_t'({2'b00, b1[i]});
    end
    du = ob[0] - 10'sd128;
    dv = ob[2] - 10'sd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < BYTES; i++) begin
        b1[i] <= in_data[8*i +: 8];
      end
      dir1 <= dir;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir2   <= dir1;
      p_bu   <= du * C1772;
      p_gu   <= du * C344;
      p_gv   <= dv * C714;
      p_rv   <= dv * C1402;
      yf1    <= SUM_W'({b1[1], {FRAC_BITS{1'b0}}});
      yf2    <= SUM_W'({b1[3], {FRAC_BITS{1'b0}}});
      p_y257 <= ob[2] * C257;
      p_y504 <= ob[1] * C504;
      p_y098 <= ob[0] * C098;
      p_u148 <= ob[2] * C148;
      p_u291 <= ob[1] * C291;
      p_u439 <= ob[0] * C439;
      p_v439 <= ob[2] * C439;
      p_v368 <= ob[1] * C368;
      p_v071 <= ob[0] * C071;
      p_z257 <= ob[5] * C257;
      p_z504 <= ob[4] * C504;
      p_z098 <= ob[3] * C098;
    end
  end

  always_comb begin
    if (dir2 == DIR_YUV2BGR) begin
      s3_next[0] = yf1 + SUM_W'(p_bu);
      s3_next[1] = yf1 - SUM_W'(p_gu) - SUM_W'(p_gv);
      s3_next[2] = yf1 + SUM_W'(p_rv);
      s3_next[3] = yf2 + SUM_W'(p_bu);
      s3_next[4] = yf2 - SUM_W'(p_gu) - SUM_W'(p_gv);
      s3_next[5] = yf2 + SUM_W'(p_rv);
    end else begin
      s3_next[0] = OFS128 - SUM_W'(p_u148) - SUM_W'(p_u291) + SUM_W'(p_u439);
      s3_next[1] = OFS16 + SUM_W'(p_y257) + SUM_W'(p_y504) + SUM_W'(p_y098);
      s3_next[2] = OFS128 + SUM_W'(p_v439) - SUM_W'(p_v368) - SUM_W'(p_v071);
      s3_next[3] = OFS16 + SUM_W'(p_z257) + SUM_W'(p_z504) + SUM_W'(p_z098);
      // the second pixel's chroma is dropped: clamp turns zero into a zero byte
      s3_next[4] = '0;
      s3_next[5] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < BYTES; i++) begin
        s3[i] <= s3_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < BYTES; i++) begin
        out_data[8*i +: 8] <= sat_floor(s3[i]);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/uyvy_bgr_color_convert_unit.sv]
// UYVY 4:2:2 <-> BGR pixel-pair colour converter, top level.
//
// Input beat (s_*): six bytes on s_tdata. Direction 0 reads U, Y1, V, Y2 from
// bytes 0..3 and ignores bytes 4..5; direction 1 reads B1, G1, R1, B2, G2, R2.
// Output beat (m_*): six bytes. Direction 0 gives B1, G1, R1, B2, G2, R2;
// direction 1 gives U, Y1, V, Y2 and two zero bytes. Chroma comes from the
// first pixel of the pair only.
// Direction is set by cfg_we/cfg_wdata; write it only while no beat is in
// flight. Each beat carries the direction in force when it was accepted.
// An input beat passes the capture, multiply, sum and clamp registers to the
// output. In steady state with m_tready high one beat per cycle goes in and out.
// All stages advance together; when the receiver holds m_tready low with a
// result waiting, the whole pipeline holds and s_tready drops, so no beat is
// lost or repeated. Bubbles stay where they are while stalled.
// Reset (rst, synchronous) clears all valid bits and sets direction to 0.
`timescale 1ns / 1ps
`default_nettype none

module uyvy_bgr_color_convert_unit
  import uyvy_cc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,  // in_byte0 .. in_byte5, 8 bits each
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata   // out_byte0 .. out_byte5, 8 bits each
);

  dir_t dir;
  logic adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= DIR_YUV2BGR;
    end else if (cfg_we) begin
      dir <= dir_t'(cfg_wdata);
    end
  end

  // advance unless a finished beat is waiting on the receiver
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  uyvy_cc_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .dir       (dir),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
